// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros: concurrent assertion helpers
// used by the rtl file that carries assertions
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

// File: rtl/core/chd_pkg.sv
// ---------------------------------------------------------------------------
// chd_pkg: shared types and constants of the chunked body decoder
// phase codes, decoder state, beat and result records, hex helper
// ---------------------------------------------------------------------------
`default_nettype none

package chd_pkg;

  // size line digit limit and the saturated size value
  localparam int MAX_SIZE_DIGITS = 8;
  localparam logic [31:0] SIZE_LIMIT = 32'((64'd1 << (4 * MAX_SIZE_DIGITS)) - 64'd1);

  // output beat layout
  localparam int OUT_TDATA_W = 48;

  // framing characters
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [1:0] STATUS_TRUNC    = 2'd2;

  // parser phase, one-hot
  typedef enum logic [6:0] {
    PH_LEAD     = 7'b0000001,
    PH_DIGITS   = 7'b0000010,
    PH_SKIP     = 7'b0000100,
    PH_SKIP_CR  = 7'b0001000,
    PH_DATA     = 7'b0010000,
    PH_TRAIL_CR = 7'b0100000,
    PH_TRAIL_LF = 7'b1000000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] chunk_remaining;
    logic [3:0]  digit_count;
    logic [31:0] byte_total;
    logic        size_overflow;
    logic        body_finished;
  } chd_state_t;

  localparam chd_state_t STATE_RESET = '{
    phase:           PH_LEAD,
    chunk_remaining: 32'd0,
    digit_count:     4'd0,
    byte_total:      32'd0,
    size_overflow:   1'b0,
    body_finished:   1'b0
  };

  // one held input beat
  typedef struct packed {
    logic       valid;
    logic [7:0] in_byte;
    logic       end_of_input;
  } chd_beat_t;

  // one result item
  typedef struct packed {
    logic        valid;
    logic [7:0]  out_byte;
    logic        data_valid;
    logic        done_res;
    logic [31:0] total_length;
    logic [1:0]  status;
  } chd_result_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_t;

  // hex digit decode, either case
  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    h.is_hex = 1'b0;
    h.value  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.is_hex = 1'b1;
      h.value  = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.is_hex = 1'b1;
      h.value  = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.is_hex = 1'b1;
      h.value  = 4'(c - 8'h57);
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/chd_in_stage.sv
// ---------------------------------------------------------------------------
// chd_in_stage: input register
// holds one accepted beat until the decoder consumes it
// ---------------------------------------------------------------------------
`default_nettype none

module chd_in_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [7:0]        s_tdata,   // [7:0] in_byte
  input  wire logic              s_tlast,   // end_of_input
  input  wire logic              advance,
  output chd_pkg::chd_beat_t     beat
);

  logic       valid;
  logic [7:0] in_byte;
  logic       end_of_input;

  // take a beat when empty or when the held beat leaves
  assign s_tready = !valid || advance;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte      <= s_tdata;
      end_of_input <= s_tlast;
    end
  end

  // held beat record
  assign beat = '{valid: valid, in_byte: in_byte, end_of_input: end_of_input};

endmodule

`default_nettype wire

// File: rtl/core/chd_step.sv
// ---------------------------------------------------------------------------
// chd_step: per-byte decode logic
// next parser state and the optional result for one body byte
// ---------------------------------------------------------------------------
`default_nettype none

module chd_step (
  input  wire chd_pkg::chd_state_t st,
  input  wire logic [7:0]          c,
  input  wire logic                last,
  output chd_pkg::chd_state_t      st_next,
  output chd_pkg::chd_result_t     res
);

  // first byte of a fresh size line
  function automatic chd_pkg::chd_state_t lead_byte(input chd_pkg::chd_state_t s,
                                                    input logic [7:0] b);
    chd_pkg::chd_state_t r;
    chd_pkg::hex_t h;
    r = s;
    h = chd_pkg::hex_value(b);
    if (b == chd_pkg::CHAR_SP || b == chd_pkg::CHAR_TAB) begin
      r.phase = chd_pkg::PH_LEAD;
    end else if (h.is_hex) begin
      r.chunk_remaining = {28'd0, h.value};
      r.digit_count     = 4'd1;
      r.phase           = chd_pkg::PH_DIGITS;
    end else begin
      r.phase = (b == chd_pkg::CHAR_CR) ? chd_pkg::PH_SKIP_CR : chd_pkg::PH_SKIP;
    end
    return r;
  endfunction

  chd_pkg::chd_state_t ns;
  chd_pkg::hex_t       hv;
  logic [31:0]         chunk_dec;
  logic                emit_data;
  logic                emit_done;
  logic                truncated;

  assign hv        = chd_pkg::hex_value(c);
  assign chunk_dec = st.chunk_remaining - 32'd1;

  // phase transitions
  always_comb begin
    ns        = st;
    emit_data = 1'b0;
    emit_done = 1'b0;
    truncated = 1'b0;
    if (!st.body_finished) begin
      case (st.phase)
        chd_pkg::PH_LEAD: begin
          ns = lead_byte(st, c);
        end
        chd_pkg::PH_DIGITS: begin
          if (hv.is_hex) begin
            if (st.digit_count < 4'(chd_pkg::MAX_SIZE_DIGITS)) begin
              ns.chunk_remaining = {st.chunk_remaining[27:0], hv.value} & chd_pkg::SIZE_LIMIT;
              ns.digit_count     = st.digit_count + 4'd1;
            end else begin
              ns.chunk_remaining = chd_pkg::SIZE_LIMIT;
              ns.size_overflow   = 1'b1;
            end
          end else begin
            ns.phase = (c == chd_pkg::CHAR_CR) ? chd_pkg::PH_SKIP_CR : chd_pkg::PH_SKIP;
          end
        end
        chd_pkg::PH_SKIP: begin
          ns.phase = (c == chd_pkg::CHAR_CR) ? chd_pkg::PH_SKIP_CR : chd_pkg::PH_SKIP;
        end
        chd_pkg::PH_SKIP_CR: begin
          if (c == chd_pkg::CHAR_LF) begin
            if (st.chunk_remaining == 32'd0) begin
              ns.body_finished = 1'b1;
              emit_done        = 1'b1;
            end else begin
              ns.phase = chd_pkg::PH_DATA;
            end
          end else begin
            ns.phase = (c == chd_pkg::CHAR_CR) ? chd_pkg::PH_SKIP_CR : chd_pkg::PH_SKIP;
          end
        end
        chd_pkg::PH_DATA: begin
          emit_data          = 1'b1;
          ns.byte_total      = st.byte_total + 32'd1;
          ns.chunk_remaining = chunk_dec;
          if (chunk_dec == 32'd0) begin
            ns.phase = chd_pkg::PH_TRAIL_CR;
          end
        end
        chd_pkg::PH_TRAIL_CR: begin
          ns.chunk_remaining = 32'd0;
          ns.digit_count     = 4'd0;
          if (c == chd_pkg::CHAR_CR) begin
            ns.phase = chd_pkg::PH_TRAIL_LF;
          end else begin
            ns = lead_byte(ns, c);
          end
        end
        chd_pkg::PH_TRAIL_LF: begin
          if (c == chd_pkg::CHAR_LF) begin
            ns.chunk_remaining = 32'd0;
            ns.digit_count     = 4'd0;
            ns.phase           = chd_pkg::PH_LEAD;
          end else begin
            ns.phase = (c == chd_pkg::CHAR_CR) ? chd_pkg::PH_SKIP_CR : chd_pkg::PH_SKIP;
          end
        end
        default: begin
          ns = chd_pkg::STATE_RESET;
        end
      endcase
      // input ran out before the zero chunk
      if (last && !emit_done) begin
        emit_done = 1'b1;
        truncated = 1'b1;
      end
    end
  end

  // the final byte rearms the decoder
  assign st_next = last ? chd_pkg::STATE_RESET : ns;

  // result record
  always_comb begin
    res.valid        = emit_data || emit_done;
    res.out_byte     = emit_data ? c : 8'd0;
    res.data_valid   = emit_data;
    res.done_res     = emit_done;
    res.total_length = ns.byte_total;
    if (truncated) begin
      res.status = chd_pkg::STATUS_TRUNC;
    end else if (ns.size_overflow) begin
      res.status = chd_pkg::STATUS_OVERFLOW;
    end else begin
      res.status = chd_pkg::STATUS_OK;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/chd_out_reg.sv
// ---------------------------------------------------------------------------
// chd_out_reg: result register
// holds one result beat for the downstream side
// ---------------------------------------------------------------------------
`default_nettype none

module chd_out_reg (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 load,
  input  wire chd_pkg::chd_result_t                 res,
  output logic                                      can_load,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic [chd_pkg::OUT_TDATA_W-1:0]           m_tdata,  // [7:0] out_byte,
                                                              // [39:8] total_length,
                                                              // [41:40] status
  output logic                                      m_tuser,  // data_valid
  output logic                                      m_tlast   // done_res
);

  // room for a new result when empty or draining this cycle
  assign can_load = !m_tvalid || m_tready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {6'd0, res.status, res.total_length, res.out_byte};
      m_tuser <= res.data_valid;
      m_tlast <= res.done_res;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/http_chunked_body_decoder.sv
// ---------------------------------------------------------------------------
// http_chunked_body_decoder: chunked transfer body decoder
// strips chunk framing from a byte stream and passes the payload on
// ---------------------------------------------------------------------------
// One body byte per clock while the result side has room: each byte sits in
// an input register, goes through a combinational state update and lands in
// a result register, which is loaded only for bytes that produce a result.
// Payload bytes come out with tuser high; the closing beat has tlast high
// and carries the total length and status (0 ok, 1 size overflow,
// 2 truncated). Bytes after the closing beat produce nothing until a byte
// with tlast arrives, which returns the decoder to its reset state.
`default_nettype none
`include "assert_macros.svh"

module http_chunked_body_decoder (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [7:0]                        s_tdata,   // [7:0] in_byte
  input  wire logic                              s_tlast,   // end_of_input
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [chd_pkg::OUT_TDATA_W-1:0]        m_tdata,   // [7:0] out_byte,
                                                            // [39:8] total_length,
                                                            // [41:40] status
  output logic                                   m_tuser,   // data_valid
  output logic                                   m_tlast    // done_res
);

  chd_pkg::chd_beat_t   beat;
  chd_pkg::chd_state_t  state;
  chd_pkg::chd_state_t  state_next;
  chd_pkg::chd_result_t res;
  logic                 can_load;
  logic                 fire;

  // held beat is decoded when the result side has room
  assign fire = beat.valid && can_load;

  // input register
  chd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .advance  (fire),
    .beat     (beat)
  );

  // per-byte decode
  chd_step u_step (
    .st      (state),
    .c       (beat.in_byte),
    .last    (beat.end_of_input),
    .st_next (state_next),
    .res     (res)
  );

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chd_pkg::STATE_RESET;
    end else if (fire) begin
      state <= state_next;
    end
  end

  // result register
  chd_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (fire && res.valid),
    .res      (res),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // checks
  `ASSERT_NEXT(a_result_lands, clk, rst, fire && res.valid, m_tvalid)
  `ASSERT_NEXT(a_last_rearms, clk, rst, fire && beat.end_of_input,
               state.phase == chd_pkg::PH_LEAD && state.byte_total == 32'd0 && !state.body_finished)
  `ASSERT_IMPLIES(a_nondata_is_done, clk, rst, m_tvalid && !m_tuser,
                  m_tlast && m_tdata[7:0] == 8'd0)
  `ASSERT_IMPLIES(a_digit_bound, clk, rst, 1'b1,
                  state.digit_count <= 4'(chd_pkg::MAX_SIZE_DIGITS))

endmodule

`default_nettype wire
